@@ src/assert_macros.svh @@
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is asserted.
`define ASSERT_CLK_RST(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

@@ src/rcfd_pkg.sv @@
package rcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int CNT_W       = 5;
    localparam int CH_W        = 11;
    localparam int NUM_CH      = 5;

    localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [15:0] TIMEOUT_RESET     = 16'd100;
    localparam logic [9:0]  STICK_LIMIT_RESET = 10'd660;
    localparam logic [15:0] TICKS_MAX         = 16'hFFFF;

    // raw minus 1024 on an 11-bit word is a flip of the top bit
    localparam logic [CH_W-1:0] CENTER_FLIP = 11'h400;

    // register indexes of the write port
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_STICK   = 1'b1;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_IDLE = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLOSED   = 3'd0,
        ST_ALIVE    = 3'd1,
        ST_LATCHED  = 3'd2,
        ST_REJECTED = 3'd3,
        ST_TIMEOUT  = 3'd4
    } status_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [15:0]                  keys;
        logic [1:0]                   buttons;
        logic [2:0][15:0]             mouse;
        logic [3:0]                   switches;
        logic [NUM_CH-1:0][CH_W-1:0]  ch;       // offsets, raw minus 1024
    } decoded_t;

endpackage

@@ src/rcfd_unpack.sv @@
module rcfd_unpack (
    input  rcfd_pkg::frame_t   frame,
    input  logic [9:0]         stick_limit,
    output rcfd_pkg::decoded_t dec,
    output logic               reject
);
    import rcfd_pkg::*;

    logic [NUM_CH-1:0][CH_W-1:0] raw;
    logic [3:0]                  stick_bad;

    function automatic logic [1:0] sw_code(input logic [1:0] r);
        logic [1:0] code;
        begin
            case (r)
                2'd1:    code = 2'd0;
                2'd3:    code = 2'd1;
                default: code = 2'd2;
            endcase
            return code;
        end
    endfunction

    function automatic logic is_bad(input logic [CH_W-1:0] r, input logic [9:0] lim);
        logic [CH_W-1:0] off;
        logic [CH_W-1:0] mag;
        begin
            off = r ^ CENTER_FLIP;
            mag = off[CH_W-1] ? (~off + 11'd1) : off;
            return mag > {1'b0, lim};
        end
    endfunction

    always_comb
    begin
        raw[0] = {frame[1][2:0], frame[0]};
        raw[1] = {frame[2][5:0], frame[1][7:3]};
        raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
        raw[3] = {frame[5][3:0], frame[4][7:1]};
        raw[4] = {frame[17][2:0], frame[16]};

        for (int i = 0; i < 4; i++)
        begin
            stick_bad[i] = is_bad(raw[i], stick_limit);
        end
        reject = |stick_bad;

        for (int i = 0; i < NUM_CH; i++)
        begin
            dec.ch[i] = raw[i] ^ CENTER_FLIP;
        end
        dec.switches = {sw_code(frame[5][7:6]), sw_code(frame[5][5:4])};
        dec.mouse[0] = {frame[7], frame[6]};
        dec.mouse[1] = {frame[9], frame[8]};
        dec.mouse[2] = {frame[11], frame[10]};
        dec.buttons  = {frame[13] == 8'd1, frame[12] == 8'd1};
        dec.keys     = {frame[15], frame[14]};
    end

endmodule

@@ src/rc_receiver_frame_decoder.sv @@
// An accepted request's result shows on the master side in the next cycle.
// Throughput: one request per clock, set by the single registered update pass; a new
// request is taken only when the slot is empty or its result is taken in the same cycle.
// Reset (rst_n low, asynchronous): link closed, counters and latched values zero,
// timeout_ms 100, stick_limit 660; the frame buffer is not cleared.
module rc_receiver_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] right_x, [21:11] right_y, [32:22] left_x, [43:33] left_y,
    // [54:44] wheel, [58:55] switches, [74:59] mouse_x, [90:75] mouse_y,
    // [106:91] mouse_scroll, [108:107] mouse_buttons, [124:109] key_mask,
    // [127:125] zero
    output logic [127:0] m_tdata,
    output logic [2:0]   m_tuser    // [2:0] status
);
    import rcfd_pkg::*;

    `include "assert_macros.svh"

    // configuration
    logic [15:0] timeout_reg;
    logic [9:0]  stick_limit_reg;

    // frame collection and link state
    frame_t            frame_reg;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [15:0]       ticks_reg,  ticks_next;
    logic              opened_reg, opened_next;
    decoded_t          latched_reg, latched_next;

    // result slot
    logic    m_valid_reg, m_valid_next;
    status_t status_reg,  status_next;

    logic     accept;
    cmd_t     cmd;
    decoded_t dec;
    logic     reject;

    function automatic status_t link_status(input logic opened, input logic [15:0] ticks,
                                            input logic [15:0] limit);
        begin
            if (!opened)
                return ST_CLOSED;
            return (ticks < limit) ? ST_ALIVE : ST_TIMEOUT;
        end
    endfunction

    // Decode the collected bytes; only used on an idle event with a full frame.
    rcfd_unpack u_unpack (
        .frame       (frame_reg),
        .stick_limit (stick_limit_reg),
        .dec         (dec),
        .reject      (reject)
    );

    // Take a new request whenever the result slot is empty or being emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);

    always_comb
    begin
        count_next   = count_reg;
        ticks_next   = ticks_reg;
        opened_next  = opened_reg;
        latched_next = latched_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (accept)
        begin
            m_valid_next = 1'b1;
            case (cmd)
                CMD_BYTE:
                begin
                    // Count on past the frame length so an overlong run is dropped.
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + 1'b1;
                    status_next = link_status(opened_reg, ticks_reg, timeout_reg);
                end
                CMD_IDLE:
                begin
                    count_next = '0;
                    if (count_reg == FRAME_LEN)
                    begin
                        // A frame of the right length opens the link and restarts
                        // the liveness count even when its values are rejected.
                        opened_next = 1'b1;
                        ticks_next  = '0;
                        if (reject)
                        begin
                            status_next = ST_REJECTED;
                        end
                        else
                        begin
                            latched_next = dec;
                            status_next  = (timeout_reg != 16'd0) ? ST_LATCHED : ST_TIMEOUT;
                        end
                    end
                    else
                    begin
                        status_next = link_status(opened_reg, ticks_reg, timeout_reg);
                    end
                end
                CMD_TICK:
                begin
                    if (ticks_reg != TICKS_MAX)
                        ticks_next = ticks_reg + 16'd1;
                    // report after the increment
                    status_next = link_status(opened_reg, ticks_next, timeout_reg);
                end
                default:
                begin
                    status_next = link_status(opened_reg, ticks_reg, timeout_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            stick_limit_reg <= STICK_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg     <= cfg_data;
                CFG_STICK:   stick_limit_reg <= cfg_data[9:0];
                default:     timeout_reg     <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ticks_reg   <= '0;
            opened_reg  <= 1'b0;
            latched_reg <= '0;
            status_reg  <= ST_CLOSED;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ticks_reg   <= ticks_next;
            opened_reg  <= opened_next;
            latched_reg <= latched_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Store a byte while the frame still has room; drop the rest.
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_BYTE && count_reg < FRAME_LEN)
        begin
            frame_reg[count_reg] <= s_tdata;
        end
    end

    // The latched values change only on an accepted request, which also
    // takes the previous result, so they drive the result payload directly.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000,
                       latched_reg.keys,
                       latched_reg.buttons,
                       latched_reg.mouse[2],
                       latched_reg.mouse[1],
                       latched_reg.mouse[0],
                       latched_reg.switches,
                       latched_reg.ch[4],
                       latched_reg.ch[3],
                       latched_reg.ch[2],
                       latched_reg.ch[1],
                       latched_reg.ch[0]};

    `ASSERT_CLK_RST(a_latched_fresh, clk, rst_n, (m_valid_reg && status_reg == ST_LATCHED) |-> (opened_reg && ticks_reg == 16'd0), "latched status without open link and fresh count")
    `ASSERT_CLK_RST(a_closed_link, clk, rst_n, (m_valid_reg && status_reg == ST_CLOSED) |-> !opened_reg, "closed status reported on an open link")
    `ASSERT_CLK_RST(a_idle_clears, clk, rst_n, (accept && cmd == CMD_IDLE) |=> (count_reg == '0), "idle event left a byte count")
    `ASSERT_CLK_RST(a_empty_ready, clk, rst_n, !m_valid_reg |-> s_tready, "empty result slot refuses requests")

endmodule

@@ sim/rc_receiver_frame_decoder_test.sv @@
`timescale 1ns / 100ps

module rc_receiver_frame_decoder_test;
    import rcfd_pkg::*;

    // Result word as it sits on m_tdata, right_x in the lowest bits.
    typedef struct packed {
        logic [2:0]  spare;
        logic [15:0] key_mask;
        logic [1:0]  mouse_buttons;
        logic [15:0] mouse_scroll;
        logic [15:0] mouse_y;
        logic [15:0] mouse_x;
        logic [3:0]  switches;
        logic [10:0] wheel;
        logic [10:0] left_y;
        logic [10:0] left_x;
        logic [10:0] right_y;
        logic [10:0] right_x;
    } rc_values_t;

    typedef struct packed {
        status_t    status;
        rc_values_t values;
    } rc_report_t;

    // One row of the directed table; typed rows carry a status read off by hand.
    typedef struct {
        cmd_t       cmd;
        logic [7:0] data;
        bit         typed;
        status_t    status;
    } directed_row_t;

    localparam int FRAME_BITS = FRAME_BYTES * 8;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = CFG_TIMEOUT;
    logic [15:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic [1:0]   s_tuser = CMD_NONE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;

    rc_receiver_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 250 MHz
    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder shadow: byte collector, liveness counter and latched values,
    // plus our copy of the two registers.
    // ------------------------------------------------------------------
    logic [7:0]       frame_bytes [FRAME_BYTES];
    logic [CNT_W-1:0] byte_tally = '0;
    logic [15:0]      ms_since_frame = '0;
    bit               link_open = 1'b0;
    rc_values_t       held_values = '0;
    logic [15:0]      timeout_limit = TIMEOUT_RESET;
    logic [9:0]       stick_window = STICK_LIMIT_RESET;

    // Reports still owed by the decoder, oldest first.
    rc_report_t       pending_reports [$];

    int mismatches = 0;
    int reports_checked = 0;
    int requests_sent = 0;
    int frames_latched = 0;
    int frames_rejected = 0;
    int timeout_reports = 0;

    int burst_left = 0;
    bit gaps_enabled = 1'b1;
    int hold_off_asks = 0;

    function automatic status_t link_state();
        if (!link_open)
            return ST_CLOSED;
        return (ms_since_frame < timeout_limit) ? ST_ALIVE : ST_TIMEOUT;
    endfunction

    function automatic logic [1:0] switch_position(logic [1:0] raw);
        if (raw == 2'd1)
            return 2'd0;
        if (raw == 2'd3)
            return 2'd1;
        return 2'd2;
    endfunction

    function automatic bit stick_out_of_range(logic [10:0] raw);
        int offset;
        offset = int'(raw) - 1024;
        if (offset < 0)
            offset = -offset;
        return offset > int'(stick_window);
    endfunction

    // Unpack a complete frame; latch it only if all four sticks are in range.
    function automatic status_t unpack_frame();
        logic [FRAME_BITS-1:0] bits;
        logic [10:0]           ch [5];
        for (int i = 0; i < FRAME_BYTES; i++)
            bits[8*i +: 8] = frame_bytes[i];
        ch[0] = bits[10:0];
        ch[1] = bits[21:11];
        ch[2] = bits[32:22];
        ch[3] = bits[43:33];
        ch[4] = bits[138:128];
        for (int i = 0; i < 4; i++)
            if (stick_out_of_range(ch[i]))
                return ST_REJECTED;
        held_values.right_x       = ch[0] ^ CENTER_FLIP;
        held_values.right_y       = ch[1] ^ CENTER_FLIP;
        held_values.left_x        = ch[2] ^ CENTER_FLIP;
        held_values.left_y        = ch[3] ^ CENTER_FLIP;
        held_values.wheel         = ch[4] ^ CENTER_FLIP;
        held_values.switches      = {switch_position(bits[47:46]), switch_position(bits[45:44])};
        held_values.mouse_x       = bits[63:48];
        held_values.mouse_y       = bits[79:64];
        held_values.mouse_scroll  = bits[95:80];
        held_values.mouse_buttons = {frame_bytes[13] == 8'd1, frame_bytes[12] == 8'd1};
        held_values.key_mask      = bits[127:112];
        return ST_LATCHED;
    endfunction

    // Advance the shadow by one request and return the report it owes.
    function automatic rc_report_t decode_request(cmd_t cmd, logic [7:0] data);
        rc_report_t r;
        case (cmd)
            CMD_BYTE:
            begin
                if (byte_tally < FRAME_LEN)
                    frame_bytes[byte_tally] = data;
                if (byte_tally != COUNT_MAX)
                    byte_tally++;
                r.status = link_state();
            end
            CMD_IDLE:
            begin
                if (byte_tally == FRAME_LEN)
                begin
                    link_open = 1'b1;
                    ms_since_frame = '0;
                    r.status = unpack_frame();
                    if (r.status == ST_REJECTED)
                        frames_rejected++;
                    else
                        frames_latched++;
                    // latched, but a zero timeout never lets the link count as alive
                    if (r.status == ST_LATCHED && link_state() != ST_ALIVE)
                        r.status = ST_TIMEOUT;
                end
                else
                    r.status = link_state();
                byte_tally = '0;
            end
            CMD_TICK:
            begin
                if (ms_since_frame != TICKS_MAX)
                    ms_since_frame++;
                r.status = link_state();
            end
            default:
                r.status = link_state();
        endcase
        if (r.status == ST_TIMEOUT)
            timeout_reports++;
        r.values = held_values;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of random length, random gaps between them.
    // Drive at the falling edge, count the handshake at the rising edge.
    // ------------------------------------------------------------------
    task automatic send_request(cmd_t cmd, logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_enabled ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        pending_reports.push_back(decode_request(cmd, data));
        burst_left--;
        if (cmd != CMD_NONE)
            requests_sent++;
    endtask

    // Drop valid and hold until every owed report has come back.
    task automatic settle_decoder();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        // margin after the last report
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(logic index, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == CFG_TIMEOUT)
            timeout_limit = value;
        else
            stick_window = value[9:0];
    endtask

    // Random frame: sticks near the current limit. A clean frame keeps all
    // four in range; otherwise one stick is pushed just past it or made random.
    function automatic logic [FRAME_BITS-1:0] random_frame(bit clean);
        logic [FRAME_BITS-1:0] bits;
        logic [10:0]           raw;
        int                    mag;
        int                    bad;
        bit                    neg;
        for (int i = 0; i < FRAME_BYTES; i++)
            bits[8*i +: 8] = 8'($urandom);
        bad = clean ? -1 : $urandom_range(0, 3);
        for (int c = 0; c < 4; c++)
        begin
            neg = $urandom_range(0, 1);
            if (c == bad && $urandom_range(0, 2) == 0)
                mag = -1;
            else if (c == bad)
            begin
                mag = int'(stick_window) + 1 + $urandom_range(0, 1);
                if (mag >= 1024)
                begin
                    mag = 1024;
                    neg = 1'b1;
                end
            end
            else if ($urandom_range(0, 3) == 0)
                mag = int'(stick_window);
            else
                mag = $urandom_range(0, int'(stick_window));
            if (mag < 0)
                raw = 11'($urandom);
            else
                raw = neg ? 11'(1024 - mag) : 11'(1024 + mag);
            bits[11*c +: 11] = raw;
        end
        // favor pressed buttons
        if ($urandom_range(0, 1) == 1)
            bits[96 +: 8] = 8'd1;
        if ($urandom_range(0, 1) == 1)
            bits[104 +: 8] = 8'd1;
        return bits;
    endfunction

    // Mostly well-formed frames with ticks between them; the rest is
    // short and overlong byte runs, stray idles, unused commands, hold-off asks and settles.
    task automatic run_random_traffic(int budget);
        logic [FRAME_BITS-1:0] frame;
        int                    stop_at;
        int                    choice;
        int                    n;
        stop_at = requests_sent + budget;
        while (requests_sent < stop_at)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 60)
            begin
                frame = random_frame($urandom_range(0, 9) < 7);
                for (int i = 0; i < FRAME_BYTES; i++)
                    send_request(CMD_BYTE, frame[8*i +: 8]);
                send_request(CMD_IDLE, 8'($urandom));
            end
            else if (choice < 72)
            begin
                if (timeout_limit < 16'd200)
                    n = $urandom_range(1, int'(timeout_limit) + 3);
                else
                    n = $urandom_range(1, 40);
                repeat (n) send_request(CMD_TICK, 8'($urandom));
            end
            else if (choice < 82)
            begin
                // too short: discarded at the idle
                n = $urandom_range(0, FRAME_BYTES - 1);
                repeat (n) send_request(CMD_BYTE, 8'($urandom));
                send_request(CMD_IDLE, 8'($urandom));
            end
            else if (choice < 90)
            begin
                // too long: extra bytes dropped, count may saturate
                n = $urandom_range(FRAME_BYTES + 1, 40);
                repeat (n) send_request(CMD_BYTE, 8'($urandom));
                send_request(CMD_IDLE, 8'($urandom));
            end
            else if (choice < 96)
                send_request(CMD_NONE, 8'($urandom));
            else if (choice < 97)
                hold_off_asks++;
            else if (choice < 98)
                settle_decoder();
            else
                send_request(CMD_IDLE, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Report side: stall on a pattern of its own, refreshed once all of its
    // bits are used; all-ready stretches now and then. A hold-off ask stalls
    // for a long run while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin
        int          hold_left = 0;
        int          asks_seen = 0;
        int          slot = 0;
        logic [15:0] pattern = '1;
        forever
        begin
            @(negedge clk);
            if (asks_seen != hold_off_asks)
            begin
                asks_seen = hold_off_asks;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (slot == 0)
                    pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : (16'($urandom) | 16'h8421);
                m_tready <= pattern[slot];
                slot = (slot + 1) % 16;
            end
        end
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Check each taken report against the oldest one owed.
    always @(posedge clk)
    begin
        rc_report_t want;
        rc_values_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_reports.size() == 0)
            begin
                $error("report with no request owed: status %0d", m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("status", want.status, m_tuser);
                compare_field("right_x", want.values.right_x, got.right_x);
                compare_field("right_y", want.values.right_y, got.right_y);
                compare_field("left_x", want.values.left_x, got.left_x);
                compare_field("left_y", want.values.left_y, got.left_y);
                compare_field("wheel", want.values.wheel, got.wheel);
                compare_field("switches", want.values.switches, got.switches);
                compare_field("mouse_x", want.values.mouse_x, got.mouse_x);
                compare_field("mouse_y", want.values.mouse_y, got.mouse_y);
                compare_field("mouse_scroll", want.values.mouse_scroll, got.mouse_scroll);
                compare_field("mouse_buttons", want.values.mouse_buttons,
                              got.mouse_buttons);
                compare_field("key_mask", want.values.key_mask, got.key_mask);
                compare_field("padding", 16'd0, got.spare);
                reports_checked++;
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #(8_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        directed_row_t rows [25];
        // Before any frame the link reads closed; a short run is discarded.
        // Rows 6..24 are one frame with all sticks centered, switches up/mid,
        // mouse axes at both ends, left button only, every key, wheel at max.
        rows = '{
            '{CMD_TICK, 8'h00, 1'b1, ST_CLOSED},
            '{CMD_NONE, 8'hA5, 1'b1, ST_CLOSED},
            '{CMD_IDLE, 8'h00, 1'b1, ST_CLOSED},
            '{CMD_BYTE, 8'h00, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_IDLE, 8'hFF, 1'b1, ST_CLOSED},
            '{CMD_BYTE, 8'h00, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h04, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h20, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h00, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h01, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hD8, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h00, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h80, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h7F, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h01, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'h02, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_BYTE, 8'hFF, 1'b0, ST_CLOSED},
            '{CMD_IDLE, 8'h00, 1'b1, ST_LATCHED}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table; override the status where it was typed in.
        for (int i = 0; i < 25; i++)
        begin
            send_request(rows[i].cmd, rows[i].data);
            if (rows[i].typed)
                pending_reports[pending_reports.size() - 1].status = rows[i].status;
        end

        // Reset settings; stall the report side early so the input backs up.
        hold_off_asks++;
        run_random_traffic(220);

        // Fastest timeout, only dead-center sticks accepted.
        settle_decoder();
        write_register(CFG_TIMEOUT, 16'd1);
        write_register(CFG_STICK, 16'($urandom) & 16'hFC00);
        run_random_traffic(120);

        // Zero timeout: the link never counts as alive; any stick but raw 0 accepted.
        settle_decoder();
        write_register(CFG_TIMEOUT, 16'd0);
        write_register(CFG_STICK, (16'($urandom) & 16'hFC00) | 16'd1023);
        run_random_traffic(120);

        // Longest timeout: open the link, then tick back to back; it stays alive.
        settle_decoder();
        write_register(CFG_TIMEOUT, 16'hFFFF);
        write_register(CFG_STICK, 16'd1023);
        gaps_enabled = 1'b0;
        for (int i = 6; i < 25; i++)
            send_request(rows[i].cmd, rows[i].data);
        repeat (40) send_request(CMD_TICK, 8'($urandom));
        gaps_enabled = 1'b1;
        run_random_traffic(100);

        // Random middle settings.
        settle_decoder();
        write_register(CFG_TIMEOUT, 16'($urandom_range(2, 300)));
        write_register(CFG_STICK, 16'($urandom_range(1, 1022)));
        hold_off_asks++;
        run_random_traffic(170);

        settle_decoder();
        write_register(CFG_TIMEOUT, 16'd37);
        write_register(CFG_STICK, 16'd660);
        run_random_traffic(120);

        // Wait out every owed report, then watch for strays.
        settle_decoder();
        repeat (4) @(posedge clk);

        $display("checked %0d reports from %0d requests: %0d frames latched, %0d rejected",
                 reports_checked, requests_sent, frames_latched, frames_rejected);
        $display("%0d timed-out reports over six register settings incl. the longest timeout",
                 timeout_reports);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ rc_receiver_frame_decoder.f @@
+incdir+src
src/rcfd_pkg.sv
src/rcfd_unpack.sv
src/rc_receiver_frame_decoder.sv
sim/rc_receiver_frame_decoder_test.sv
